// ===== src/vlc_integer_decoder_macros.svh =====
// Assertion macros shared by the decoder's modules.
// Every macro expects signals named clk and arst_n where it is used.
`ifndef VLC_INTEGER_DECODER_MACROS_SVH
`define VLC_INTEGER_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset
`define VID_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("vlc decoder check failed");
// Antecedent implies consequent in the same cycle
`define VID_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vlc decoder check failed");
// Antecedent implies consequent in the next cycle
`define VID_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vlc decoder check failed");
`else
`define VID_ASSERT(lbl, cond)
`define VID_ASSERT_IMP(lbl, ante, cons)
`define VID_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/vid_pkg.sv =====
// Shared types and constants of the compact VLC integer decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package vid_pkg;

	localparam int DATA_W            = 8;
	localparam int VALUE_W           = 64;
	localparam int USED_W            = 4;
	localparam int STATUS_W          = 2;
	localparam int LANES             = VALUE_W / DATA_W;
	localparam int IDX_W             = $clog2(LANES);
	localparam int MAX_PAYLOAD_BYTES = 8;
	localparam int M_TDATA_W         = ((VALUE_W + USED_W + 7) / 8) * 8;
	localparam int Q_DEPTH           = 2;

	localparam logic [DATA_W-1:0] NULL_BYTE = 8'hc0;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADLEN = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNC  = 2'd2;

	// Commands passed from the front to the back
	typedef enum logic [2:0] {
		OP_IMM    = 3'd0, // one-byte value
		OP_NULL   = 3'd1, // null marker
		OP_BADLEN = 3'd2, // length field too large
		OP_TRUNC  = 3'd3, // value cut off by end of buffer
		OP_SHDR   = 3'd4, // header of the 14-bit form
		OP_SEND   = 3'd5, // second byte of the 14-bit form
		OP_LBYTE  = 3'd6, // inner payload byte of the long form
		OP_LEND   = 3'd7  // last payload byte of the long form
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] data;
		logic              sgn;
		logic [IDX_W-1:0]  idx;
		logic [USED_W-1:0] used;
	} cmd_t;

endpackage

// ===== src/vlc_integer_decoder.sv =====
// Compact VLC integer decoder: one stream byte per transaction in, one result per value out.
// A completing byte passes through the command queue and the back result register before m_tvalid rises.
// Throughput: one byte per cycle while the command queue has room; s_tready falls when it is full.
// A two-entry command queue lets the input keep flowing while a result waits.
// Reset: arst_n clears framing, queue and result-valid state at once; no clearing pass.
// Depends on vid_pkg, vid_front, vid_queue and vid_back.
module vlc_integer_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // data_byte
	input  logic                            s_tuser,  // is_signed
	input  logic                            s_tlast,  // end_of_buffer
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [vid_pkg::M_TDATA_W-1:0]   m_tdata,  // value[63:0], bytes_used[67:64], zero pad
	output logic [2:0]                      m_tuser   // is_null[0], status[2:1]
);

	logic                          fire;
	logic                          push;
	logic                          q_full;
	logic                          pop;
	logic                          head_valid;
	vid_pkg::cmd_t                 push_cmd;
	vid_pkg::cmd_t                 head_cmd;
	logic [vid_pkg::VALUE_W-1:0]   res_value;
	logic                          res_null;
	logic [vid_pkg::STATUS_W-1:0]  res_status;
	logic [vid_pkg::USED_W-1:0]    res_used;

	assign s_tready = !q_full;
	assign fire     = s_tvalid && s_tready;

	vid_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.data_byte     (s_tdata),
		.is_signed     (s_tuser),
		.end_of_buffer (s_tlast),
		.push          (push),
		.cmd           (push_cmd)
	);

	vid_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	vid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.pop        (pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_value  (res_value),
		.res_null   (res_null),
		.res_status (res_status),
		.res_used   (res_used)
	);

	// Pack the result fields onto the master side
	assign m_tdata = {{(vid_pkg::M_TDATA_W - vid_pkg::VALUE_W - vid_pkg::USED_W){1'b0}},
		res_used, res_value};
	assign m_tuser = {res_status, res_null};

endmodule

// ===== src/vid_front.sv =====
// Front end: accepts stream bytes, tracks the framing and classifies each byte.
// Depends on vid_pkg; feeds commands into vid_queue.
module vid_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [vid_pkg::DATA_W-1:0]  data_byte,
	input  logic                        is_signed,
	input  logic                        end_of_buffer,
	output logic                        push,
	output vid_pkg::cmd_t               cmd
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_SHORT = 3'b010,
		PH_LONG  = 3'b100
	} phase_t;

	phase_t                     phase_q, phase_n;
	logic [vid_pkg::USED_W-1:0] left_q, left_n;
	logic [vid_pkg::USED_W-1:0] cnt_q, cnt_n;
	logic                       sgn_q, sgn_n;
	logic                       has_cmd;
	logic [vid_pkg::USED_W-1:0] cnt_inc, cnt_dec;
	logic [5:0]                 len;

	assign cnt_inc = cnt_q + 4'd1;
	assign cnt_dec = cnt_q - 4'd1;
	assign len     = data_byte[5:0];

	// Classify the byte against the current framing phase
	always_comb begin
		phase_n  = phase_q;
		left_n   = left_q;
		cnt_n    = cnt_q;
		sgn_n    = sgn_q;
		has_cmd  = 1'b1;
		cmd.op   = vid_pkg::OP_IMM;
		cmd.data = data_byte;
		cmd.sgn  = sgn_q;
		cmd.idx  = cnt_dec[vid_pkg::IDX_W-1:0];
		cmd.used = cnt_inc;
		case (phase_q)
			PH_SHORT: begin
				cmd.op  = vid_pkg::OP_SEND;
				phase_n = PH_IDLE;
				cnt_n   = cnt_inc;
			end
			PH_LONG: begin
				cnt_n  = cnt_inc;
				left_n = left_q - 4'd1;
				if (left_q == 4'd1) begin
					cmd.op  = vid_pkg::OP_LEND;
					phase_n = PH_IDLE;
				end else if (end_of_buffer) begin
					cmd.op  = vid_pkg::OP_TRUNC;
					phase_n = PH_IDLE;
				end else begin
					cmd.op = vid_pkg::OP_LBYTE;
				end
			end
			default: begin
				// Header byte; an unknown phase is treated as idle
				phase_n  = PH_IDLE;
				left_n   = '0;
				cnt_n    = 4'd1;
				sgn_n    = is_signed;
				cmd.sgn  = is_signed;
				cmd.used = 4'd1;
				if (!data_byte[7]) begin
					cmd.op = vid_pkg::OP_IMM;
				end else if (!data_byte[6]) begin
					if (end_of_buffer) begin
						cmd.op = vid_pkg::OP_TRUNC;
					end else begin
						cmd.op  = vid_pkg::OP_SHDR;
						phase_n = PH_SHORT;
					end
				end else if (data_byte == vid_pkg::NULL_BYTE) begin
					cmd.op = vid_pkg::OP_NULL;
				end else if (len > 6'(vid_pkg::MAX_PAYLOAD_BYTES)) begin
					cmd.op = vid_pkg::OP_BADLEN;
				end else if (end_of_buffer) begin
					cmd.op = vid_pkg::OP_TRUNC;
				end else begin
					// Long header: nothing for the back end until payload arrives
					has_cmd = 1'b0;
					left_n  = len[vid_pkg::USED_W-1:0];
					phase_n = PH_LONG;
				end
			end
		endcase
	end

	assign push = fire && has_cmd;

	// Advance the framing state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= '0;
			cnt_q   <= '0;
			sgn_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			left_q  <= left_n;
			cnt_q   <= cnt_n;
			sgn_q   <= sgn_n;
		end
	end

endmodule

// ===== src/vid_queue.sv =====
// Two-entry command queue between the front and the back end.
// Depends on vid_pkg and the assertion macros header.
`include "vlc_integer_decoder_macros.svh"
module vid_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vid_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output vid_pkg::cmd_t head_cmd
);

	localparam int PTR_W = $clog2(vid_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(vid_pkg::Q_DEPTH + 1);

	vid_pkg::cmd_t     mem_q [vid_pkg::Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == CNT_W'(vid_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`VID_ASSERT(q_count_bound, count_q <= CNT_W'(vid_pkg::Q_DEPTH))
	`VID_ASSERT(q_ptr_match, (wr_ptr_q ^ rd_ptr_q) == count_q[PTR_W-1:0])
	`VID_ASSERT_NXT(q_fill, do_push && !do_pop && count_q == '0, head_valid)

endmodule

// ===== src/vid_back.sv =====
// Back end: assembles values from commands and holds the result register.
// Depends on vid_pkg and the assertion macros header.
`include "vlc_integer_decoder_macros.svh"
module vid_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  vid_pkg::cmd_t                 cmd,
	output logic                          pop,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [vid_pkg::VALUE_W-1:0]   res_value,
	output logic                          res_null,
	output logic [vid_pkg::STATUS_W-1:0]  res_status,
	output logic [vid_pkg::USED_W-1:0]    res_used
);

	localparam int DW = vid_pkg::DATA_W;

	logic [vid_pkg::VALUE_W-1:0]  acc_q;
	logic                         m_valid_q;
	logic [vid_pkg::VALUE_W-1:0]  m_value_q;
	logic                         m_null_q;
	logic [vid_pkg::STATUS_W-1:0] m_status_q;
	logic [vid_pkg::USED_W-1:0]   m_used_q;

	logic                         emits;
	logic                         slot_free;
	logic                         take;
	logic [vid_pkg::VALUE_W-1:0]  value_n;
	logic                         null_n;
	logic [vid_pkg::STATUS_W-1:0] status_n;
	logic [vid_pkg::VALUE_W-1:0]  long_value;
	logic                         ext7, ext14, extl;

	assign emits     = !(cmd.op inside {vid_pkg::OP_SHDR, vid_pkg::OP_LBYTE});
	assign slot_free = !m_valid_q || res_ready;
	assign take      = cmd_valid && (!emits || slot_free);
	assign pop       = take;

	assign ext7  = cmd.sgn && cmd.data[6];
	assign ext14 = cmd.sgn && cmd.data[7];
	assign extl  = cmd.sgn && cmd.data[7];

	// Long form: lanes below the last byte from the accumulator, fill above it
	always_comb begin
		for (int k = 0; k < vid_pkg::LANES; k++) begin
			if (k < int'(cmd.idx)) begin
				long_value[k*DW +: DW] = acc_q[k*DW +: DW];
			end else if (k == int'(cmd.idx)) begin
				long_value[k*DW +: DW] = cmd.data;
			end else begin
				long_value[k*DW +: DW] = {DW{extl}};
			end
		end
	end

	// Select the result for the command
	always_comb begin
		value_n  = '0;
		null_n   = 1'b0;
		status_n = vid_pkg::ST_OK;
		case (cmd.op)
			vid_pkg::OP_IMM:    value_n = {{(vid_pkg::VALUE_W-7){ext7}}, cmd.data[6:0]};
			vid_pkg::OP_NULL:   null_n = 1'b1;
			vid_pkg::OP_BADLEN: status_n = vid_pkg::ST_BADLEN;
			vid_pkg::OP_TRUNC:  status_n = vid_pkg::ST_TRUNC;
			vid_pkg::OP_SEND: begin
				value_n = {{(vid_pkg::VALUE_W-14){ext14}}, cmd.data, acc_q[5:0]};
			end
			vid_pkg::OP_LEND:   value_n = long_value;
			default:            value_n = '0;
		endcase
	end

	// Gather header bits and payload lanes
	always_ff @(posedge clk) begin
		if (take && cmd.op == vid_pkg::OP_SHDR) begin
			acc_q[5:0] <= cmd.data[5:0];
		end
		if (take && cmd.op == vid_pkg::OP_LBYTE) begin
			acc_q[cmd.idx*DW +: DW] <= cmd.data;
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (take && emits) begin
			m_valid_q <= 1'b1;
		end else if (res_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emits) begin
			m_value_q  <= value_n;
			m_null_q   <= null_n;
			m_status_q <= status_n;
			m_used_q   <= cmd.used;
		end
	end

	assign res_valid  = m_valid_q;
	assign res_value  = m_value_q;
	assign res_null   = m_null_q;
	assign res_status = m_status_q;
	assign res_used   = m_used_q;

	`VID_ASSERT_IMP(b_err_zero, m_valid_q && m_status_q != vid_pkg::ST_OK, m_value_q == '0)
	`VID_ASSERT_IMP(b_null_one, m_valid_q && m_null_q,
		m_used_q == 4'd1 && m_status_q == vid_pkg::ST_OK && m_value_q == '0)
	`VID_ASSERT_IMP(b_used_range, m_valid_q,
		m_used_q != '0 && m_used_q <= 4'(vid_pkg::MAX_PAYLOAD_BYTES + 1))

endmodule

// ===== tb/sv/vlc_integer_decoder_tb.sv =====
// Self-checking testbench for vlc_integer_decoder: drives encoded bytes, predicts each result.
// Directed rows first, then random well-formed and broken values with random idling.
// Depends on vid_pkg and the decoder RTL.
`timescale 1ns / 1ps

module vlc_integer_decoder_tb;

	localparam int RANDOM_BYTES = 1350;
	localparam int MAX_REPORTS  = 10;

	// One decoded result as the block reports it
	typedef struct packed {
		logic [63:0]                  value;
		logic                         is_null;
		logic [vid_pkg::STATUS_W-1:0] status;
		logic [vid_pkg::USED_W-1:0]   used;
	} vlc_result_t;

	// One directed stimulus row; res holds the expected result where it is typed in
	typedef struct packed {
		logic [7:0]  b;
		logic        sgn;
		logic        eob;
		logic        typed;
		vlc_result_t res;
	} dir_row_t;

	typedef enum logic [2:0] {
		DEC_IDLE  = 3'b001,
		DEC_SHORT = 3'b010,
		DEC_LONG  = 3'b100
	} dec_phase_t;

	localparam vlc_result_t NO_RESULT = '0;
	localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;

	localparam int DIRECTED_ROWS = 25;
	localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
		// one-byte form: extremes, both signs
		'{8'h00, 1'b0, 1'b0, 1'b1, '{64'h0, 1'b0, vid_pkg::ST_OK, 4'd1}},
		'{8'h7f, 1'b0, 1'b0, 1'b1, '{64'h7f, 1'b0, vid_pkg::ST_OK, 4'd1}},
		'{8'h7f, 1'b1, 1'b0, 1'b1, '{ALL_ONES, 1'b0, vid_pkg::ST_OK, 4'd1}},
		'{8'h40, 1'b1, 1'b0, 1'b1, '{64'hffff_ffff_ffff_ffc0, 1'b0, vid_pkg::ST_OK, 4'd1}},
		// end of buffer on a completing byte changes nothing
		'{8'h3f, 1'b1, 1'b1, 1'b1, '{64'h3f, 1'b0, vid_pkg::ST_OK, 4'd1}},
		// null marker
		'{8'hc0, 1'b1, 1'b0, 1'b1, '{64'h0, 1'b1, vid_pkg::ST_OK, 4'd1}},
		// length field too large, also with end of buffer
		'{8'hc9, 1'b0, 1'b0, 1'b1, '{64'h0, 1'b0, vid_pkg::ST_BADLEN, 4'd1}},
		'{8'hff, 1'b0, 1'b1, 1'b1, '{64'h0, 1'b0, vid_pkg::ST_BADLEN, 4'd1}},
		// truncated on the header itself
		'{8'h80, 1'b0, 1'b1, 1'b1, '{64'h0, 1'b0, vid_pkg::ST_TRUNC, 4'd1}},
		'{8'hc1, 1'b0, 1'b1, 1'b1, '{64'h0, 1'b0, vid_pkg::ST_TRUNC, 4'd1}},
		// 14-bit form, signed all ones, then unsigned zero closed by end of buffer
		'{8'hbf, 1'b1, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b1, '{ALL_ONES, 1'b0, vid_pkg::ST_OK, 4'd2}},
		'{8'h80, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1, 1'b1, '{64'h0, 1'b0, vid_pkg::ST_OK, 4'd2}},
		// longest payload, all ones
		'{8'hc8, 1'b1, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'hff, 1'b0, 1'b1, 1'b1, '{ALL_ONES, 1'b0, vid_pkg::ST_OK, 4'd9}},
		// payload cut off by end of buffer
		'{8'hc2, 1'b0, 1'b0, 1'b0, NO_RESULT},
		'{8'h12, 1'b0, 1'b1, 1'b1, '{64'h0, 1'b0, vid_pkg::ST_TRUNC, 4'd2}}
	};

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata  = 8'h00;
	logic                            s_tuser  = 1'b0;
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [vid_pkg::M_TDATA_W-1:0]   m_tdata;
	logic [2:0]                      m_tuser;

	// Predictor state
	dec_phase_t             dec_phase    = DEC_IDLE;
	logic [3:0]             payload_left = 4'd0;
	logic [63:0]            gathered     = 64'd0;
	logic                   sign_sel     = 1'b0;
	logic [3:0]             used_count   = 4'd0;

	vlc_result_t            pending_values [$];
	int                     bytes_sent   = 0;
	int                     fail_count   = 0;
	int                     stall_left   = 0;
	bit                     calm_in      = 1'b0;
	bit                     calm_out     = 1'b0;

	vlc_integer_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one
	function automatic int draw_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Advance the predicted decoder by one byte; got is set when a value ends
	task automatic decode_byte(input logic [7:0] b, input logic sg, input logic eb,
			output logic got, output vlc_result_t r);
		logic [63:0] v;
		logic [2:0]  lane;
		int          nbits;
		got = 1'b0;
		r = NO_RESULT;
		case (dec_phase)
			DEC_SHORT: begin
				used_count = used_count + 4'd1;
				v = {50'd0, b, gathered[5:0]};
				if (sign_sel && b[7])
					v[63:14] = '1;
				r = '{v, 1'b0, vid_pkg::ST_OK, used_count};
				got = 1'b1;
			end
			DEC_LONG: begin
				lane = 3'(used_count - 4'd1);
				gathered = gathered | (64'(b) << (8 * lane));
				used_count = used_count + 4'd1;
				payload_left = payload_left - 4'd1;
				if (payload_left == 4'd0) begin
					nbits = 8 * int'(used_count - 4'd1);
					v = gathered;
					// sign-extend from the top payload bit; a full 64-bit value needs none
					if (sign_sel && nbits >= 8 && nbits < 64 && v[nbits-1])
						v = v | ~((64'd1 << nbits) - 64'd1);
					r = '{v, 1'b0, vid_pkg::ST_OK, used_count};
					got = 1'b1;
				end else if (eb) begin
					r = '{64'd0, 1'b0, vid_pkg::ST_TRUNC, used_count};
					got = 1'b1;
				end
			end
			default: begin
				// header byte
				sign_sel = sg;
				used_count = 4'd1;
				gathered = 64'd0;
				payload_left = 4'd0;
				if (!b[7]) begin
					v = 64'(b);
					if (sg && b[6])
						v[63:7] = '1;
					r = '{v, 1'b0, vid_pkg::ST_OK, 4'd1};
					got = 1'b1;
				end else if (!b[6]) begin
					if (eb) begin
						r = '{64'd0, 1'b0, vid_pkg::ST_TRUNC, 4'd1};
						got = 1'b1;
					end else begin
						gathered = {58'd0, b[5:0]};
						dec_phase = DEC_SHORT;
					end
				end else if (b == vid_pkg::NULL_BYTE) begin
					r = '{64'd0, 1'b1, vid_pkg::ST_OK, 4'd1};
					got = 1'b1;
				end else if (int'(b[5:0]) > vid_pkg::MAX_PAYLOAD_BYTES) begin
					r = '{64'd0, 1'b0, vid_pkg::ST_BADLEN, 4'd1};
					got = 1'b1;
				end else if (eb) begin
					r = '{64'd0, 1'b0, vid_pkg::ST_TRUNC, 4'd1};
					got = 1'b1;
				end else begin
					payload_left = b[3:0];
					dec_phase = DEC_LONG;
				end
			end
		endcase
		if (got) begin
			dec_phase = DEC_IDLE;
			payload_left = 4'd0;
			gathered = 64'd0;
			used_count = 4'd0;
		end
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Offer one byte, hold it until accepted, then record what it should produce
	task automatic send_byte(input logic [7:0] b, input logic sg, input logic eb,
			input logic typed = 1'b0, input vlc_result_t typed_res = '0);
		int          gap;
		logic        got;
		vlc_result_t predicted;
		gap = draw_gap(calm_in);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= sg;
		s_tlast <= eb;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
		decode_byte(b, sg, eb, got, predicted);
		if (typed)
			pending_values.push_back(typed_res);
		else if (got)
			pending_values.push_back(predicted);
	endtask

	// Hold the input off until every outstanding result has arrived
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_values.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] payload_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'hff;
		if (r == 1)
			return 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// One random value: mostly well-formed, sometimes cut short, with a length field too large, or plain noise
	task automatic send_value();
		int         kind;
		int         n;
		logic       sg;
		kind = $urandom_range(99);
		sg = 1'($urandom_range(1));
		if (kind < 15) begin
			send_byte(8'($urandom_range(127)), sg, ($urandom_range(15) == 0));
		end else if (kind < 35) begin
			send_byte(8'h80 | 8'($urandom_range(63)), sg, ($urandom_range(15) == 0));
			send_byte(payload_byte(), 1'($urandom_range(1)), ($urandom_range(15) == 0));
		end else if (kind < 42) begin
			send_byte(vid_pkg::NULL_BYTE, sg, ($urandom_range(15) == 0));
		end else if (kind < 82) begin
			n = $urandom_range(vid_pkg::MAX_PAYLOAD_BYTES, 1);
			send_byte(8'hc0 | 8'(n), sg, ($urandom_range(15) == 0));
			repeat (n)
				send_byte(payload_byte(), 1'($urandom_range(1)),
					($urandom_range(15) == 0));
		end else if (kind < 90) begin
			send_byte(8'hc0 | 8'($urandom_range(63, vid_pkg::MAX_PAYLOAD_BYTES + 1)), sg,
				1'($urandom_range(1)));
		end else begin
			repeat ($urandom_range(4, 1))
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	// Compare one result transaction with the oldest expectation
	task automatic check_result();
		vlc_result_t seen;
		vlc_result_t want;
		seen = '{m_tdata[63:0], m_tuser[0], m_tuser[2:1], m_tdata[67:64]};
		if (pending_values.size() == 0) begin
			note_failure($sformatf("unexpected result value=%h null=%b status=%0d used=%0d",
				seen.value, seen.is_null, seen.status, seen.used));
		end else begin
			want = pending_values.pop_front();
			if (seen.value !== want.value || seen.is_null !== want.is_null ||
					seen.status !== want.status || seen.used !== want.used)
				note_failure($sformatf({"mismatch: expected value=%h null=%b status=%0d ",
					"used=%0d, got value=%h null=%b status=%0d used=%0d"},
					want.value, want.is_null, want.status, want.used,
					seen.value, seen.is_null, seen.status, seen.used));
		end
	endtask

	// Take results and stall the output at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall_left = draw_gap(calm_out);
			m_tready <= (stall_left == 0);
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_byte(DIRECTED[i].b, DIRECTED[i].sgn, DIRECTED[i].eob,
				DIRECTED[i].typed, DIRECTED[i].res);
		drain_results();
		while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
			// switch between idling and back-to-back stretches
			if ($urandom_range(49) == 0) begin
				calm_in = ($urandom_range(2) == 0);
				calm_out = ($urandom_range(2) == 0);
			end
			if ($urandom_range(199) == 0)
				drain_results();
			send_value();
		end
		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_values.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : watchdog
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== vlc_integer_decoder.f =====
+incdir+src
src/vid_pkg.sv
src/vid_front.sv
src/vid_queue.sv
src/vid_back.sv
src/vlc_integer_decoder.sv
tb/sv/vlc_integer_decoder_tb.sv
